// ----- hdl/dpbp_pkg.sv -----
// shared types, constants and helper functions for the depth pixel back-projection core
package dpbp_pkg;

   // fixed field widths
   localparam int PIXEL_BITS     = 12;
   localparam int DEPTH_IN_BITS  = 16;
   localparam int LEVEL_BITS     = 8;
   localparam int FOCAL_BITS     = 24;
   localparam int CENTER_BITS    = 20;
   localparam int FRAC_BITS      = 16;
   localparam int SUBPIX_BITS    = 8;
   localparam int FOCAL_MIN_BITS = 8;
   localparam int OUT_XY_BITS    = 48;
   localparam int OUT_Z_BITS     = 32;
   localparam int COLOR_Q_BITS   = 17;

   // configuration port
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // register reset values
   localparam logic [FOCAL_BITS-1:0]  FOCAL_RESET    = 24'd133376;
   localparam logic [CENTER_BITS-1:0] CENTER_X_RESET = 20'd81920;
   localparam logic [CENTER_BITS-1:0] CENTER_Y_RESET = 20'd61440;
   localparam logic [FOCAL_BITS-1:0]  FOCAL_MIN      = 24'd256;

   // saturation limits for the signed 48-bit outputs
   localparam logic [OUT_XY_BITS-1:0] XY_MAX = {1'b0, {(OUT_XY_BITS-1){1'b1}}};
   localparam logic [OUT_XY_BITS-1:0] XY_MIN = {1'b1, {(OUT_XY_BITS-1){1'b0}}};

   localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = 8'hFF;

   // register map
   typedef enum logic [1:0] {
      REG_MODE     = 2'd0,
      REG_FOCAL    = 2'd1,
      REG_CENTER_X = 2'd2,
      REG_CENTER_Y = 2'd3
   } reg_index_type;

   // mode codes
   localparam logic MODE_DEPTH = 1'b0;
   localparam logic MODE_COLOR = 1'b1;

   // live configuration seen by the datapath
   typedef struct packed {
      logic                   mode;
      logic [FOCAL_BITS-1:0]  focal;
      logic [CENTER_BITS-1:0] center_x;
      logic [CENTER_BITS-1:0] center_y;
   } cfg_type;

   // data that rides alongside the divider lanes
   typedef struct packed {
      logic                    mode;
      logic                    neg_x;
      logic                    neg_y;
      logic [OUT_Z_BITS-1:0]   point_z;
      logic [COLOR_Q_BITS-1:0] red_q;
      logic [COLOR_Q_BITS-1:0] green_q;
   } side_type;

   // level * 2^16 / 255 truncated: level * 257 plus one at full scale
   function automatic logic [COLOR_Q_BITS-1:0] color_norm(input logic [LEVEL_BITS-1:0] level);
      logic [COLOR_Q_BITS-1:0] base;
      base = {1'b0, level, level};
      return base + COLOR_Q_BITS'(level == LEVEL_FULL);
   endfunction

endpackage

// ----- hdl/dpbp_csr.sv -----
// configuration registers behind the APB-style port
module dpbp_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [dpbp_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [dpbp_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [dpbp_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready,
   output dpbp_pkg::cfg_type                    cfg
);

   logic                                 mode_ff;
   logic [dpbp_pkg::FOCAL_BITS-1:0]      focal_ff;
   logic [dpbp_pkg::CENTER_BITS-1:0]     center_x_ff;
   logic [dpbp_pkg::CENTER_BITS-1:0]     center_y_ff;
   logic                                 write_en;
   dpbp_pkg::reg_index_type              reg_index;

   assign pready    = 1'b1;
   assign write_en  = psel & penable & pwrite;
   assign reg_index = dpbp_pkg::reg_index_type'(paddr[dpbp_pkg::CSR_ADDR_BITS-1:2]);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= dpbp_pkg::MODE_DEPTH;
         focal_ff    <= dpbp_pkg::FOCAL_RESET;
         center_x_ff <= dpbp_pkg::CENTER_X_RESET;
         center_y_ff <= dpbp_pkg::CENTER_Y_RESET;
      end else if (write_en) begin
         unique case (reg_index)
            dpbp_pkg::REG_MODE:     mode_ff     <= pwdata[0];
            dpbp_pkg::REG_FOCAL:    focal_ff    <= pwdata[dpbp_pkg::FOCAL_BITS-1:0];
            dpbp_pkg::REG_CENTER_X: center_x_ff <= pwdata[dpbp_pkg::CENTER_BITS-1:0];
            dpbp_pkg::REG_CENTER_Y: center_y_ff <= pwdata[dpbp_pkg::CENTER_BITS-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (reg_index)
         dpbp_pkg::REG_MODE:     prdata = dpbp_pkg::CSR_DATA_BITS'(mode_ff);
         dpbp_pkg::REG_FOCAL:    prdata = dpbp_pkg::CSR_DATA_BITS'(focal_ff);
         dpbp_pkg::REG_CENTER_X: prdata = dpbp_pkg::CSR_DATA_BITS'(center_x_ff);
         dpbp_pkg::REG_CENTER_Y: prdata = dpbp_pkg::CSR_DATA_BITS'(center_y_ff);
         default:                prdata = '0;
      endcase
   end

   // focal lengths under one pixel are clamped so the divisor is never zero
   always_comb begin
      cfg.mode     = mode_ff;
      cfg.focal    = (focal_ff < dpbp_pkg::FOCAL_MIN) ? dpbp_pkg::FOCAL_MIN : focal_ff;
      cfg.center_x = center_x_ff;
      cfg.center_y = center_y_ff;
   end

endmodule

// ----- hdl/dpbp_front.sv -----
// front stages: principal point offsets, then offset magnitude times depth
module dpbp_front #(
   parameter int COL_BITS   = 12,
   parameter int DEPTH_BITS = 16,
   parameter int MAG_BITS   = 20
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  in_valid,
   input  logic [dpbp_pkg::PIXEL_BITS-1:0]       pixel_column,
   input  logic [dpbp_pkg::PIXEL_BITS-1:0]       pixel_row,
   input  logic [dpbp_pkg::DEPTH_IN_BITS-1:0]    depth_value,
   input  logic [dpbp_pkg::LEVEL_BITS-1:0]       red_level,
   input  logic [dpbp_pkg::LEVEL_BITS-1:0]       green_level,
   input  logic [dpbp_pkg::LEVEL_BITS-1:0]       blue_level,
   input  dpbp_pkg::cfg_type                     cfg,
   output logic                                  out_valid,
   output logic [1:0][MAG_BITS+DEPTH_BITS-1:0]   prod,
   output dpbp_pkg::side_type                    side
);

   localparam int OFF_BITS  = MAG_BITS + 1;
   localparam int PROD_BITS = MAG_BITS + DEPTH_BITS;

   logic [OFF_BITS-1:0]       col_ext;
   logic [OFF_BITS-1:0]       row_ext;
   logic [OFF_BITS-1:0]       diff_x;
   logic [OFF_BITS-1:0]       diff_y;
   logic [OFF_BITS-1:0]       abs_x;
   logic [OFF_BITS-1:0]       abs_y;
   logic [DEPTH_BITS-1:0]     depth_low;
   dpbp_pkg::side_type        side_in;

   logic                      valid_a_ff;
   logic [MAG_BITS-1:0]       mag_x_ff;
   logic [MAG_BITS-1:0]       mag_y_ff;
   logic [DEPTH_BITS-1:0]     depth_ff;
   dpbp_pkg::side_type        side_a_ff;

   logic                      valid_b_ff;
   logic [1:0][PROD_BITS-1:0] prod_ff;
   dpbp_pkg::side_type        side_b_ff;

   // signed offsets in 1/256-pixel subpixels, split into sign and magnitude
   always_comb begin
      col_ext   = OFF_BITS'({pixel_column[COL_BITS-1:0], {dpbp_pkg::SUBPIX_BITS{1'b0}}});
      row_ext   = OFF_BITS'({pixel_row[COL_BITS-1:0], {dpbp_pkg::SUBPIX_BITS{1'b0}}});
      diff_x    = col_ext - OFF_BITS'(cfg.center_x);
      diff_y    = row_ext - OFF_BITS'(cfg.center_y);
      abs_x     = diff_x[OFF_BITS-1] ? (~diff_x + OFF_BITS'(1)) : diff_x;
      abs_y     = diff_y[OFF_BITS-1] ? (~diff_y + OFF_BITS'(1)) : diff_y;
      depth_low = depth_value[DEPTH_BITS-1:0];

      side_in.mode    = cfg.mode;
      side_in.neg_x   = diff_x[OFF_BITS-1];
      side_in.neg_y   = diff_y[OFF_BITS-1];
      side_in.red_q   = dpbp_pkg::color_norm(red_level);
      side_in.green_q = dpbp_pkg::color_norm(green_level);
      if (cfg.mode == dpbp_pkg::MODE_COLOR) begin
         side_in.point_z = dpbp_pkg::OUT_Z_BITS'(dpbp_pkg::color_norm(blue_level));
      end else begin
         side_in.point_z = dpbp_pkg::OUT_Z_BITS'({depth_low, {dpbp_pkg::FRAC_BITS{1'b0}}});
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else if (advance) begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
      end
   end

   // stage a: offsets, stage b: products
   always_ff @(posedge clock) begin
      if (advance) begin
         mag_x_ff   <= abs_x[MAG_BITS-1:0];
         mag_y_ff   <= abs_y[MAG_BITS-1:0];
         depth_ff   <= depth_low;
         side_a_ff  <= side_in;
         prod_ff[0] <= PROD_BITS'(mag_x_ff) * PROD_BITS'(depth_ff);
         prod_ff[1] <= PROD_BITS'(mag_y_ff) * PROD_BITS'(depth_ff);
         side_b_ff  <= side_a_ff;
      end
   end

   assign out_valid = valid_b_ff;
   assign prod      = prod_ff;
   assign side      = side_b_ff;

endmodule

// ----- hdl/dpbp_div_pipe.sv -----
// pipelined restoring divider: two lanes share the focal divisor, one quotient bit per stage
module dpbp_div_pipe #(
   parameter int PROD_BITS = 36
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  in_valid,
   input  logic [1:0][PROD_BITS-1:0]             prod,
   input  logic [dpbp_pkg::FOCAL_BITS-1:0]       focal,
   input  dpbp_pkg::side_type                    side_in,
   output logic                                  out_valid,
   output logic [1:0][PROD_BITS+dpbp_pkg::FRAC_BITS-dpbp_pkg::FOCAL_MIN_BITS-1:0] quot,
   output dpbp_pkg::side_type                    side_out
);

   localparam int FB       = dpbp_pkg::FOCAL_BITS;
   localparam int Q_BITS   = PROD_BITS + dpbp_pkg::FRAC_BITS - dpbp_pkg::FOCAL_MIN_BITS;
   localparam int LOW_BITS = PROD_BITS - dpbp_pkg::FOCAL_MIN_BITS;

   // acc holds the numerator bits still to shift in, quotient bits fill from the bottom
   logic                         valid_ff [Q_BITS];
   logic [1:0][FB-1:0]           rem_ff   [Q_BITS];
   logic [1:0][Q_BITS-1:0]       acc_ff   [Q_BITS];
   dpbp_pkg::side_type           side_ff  [Q_BITS];

   logic [1:0][FB-1:0]           prev_rem [Q_BITS];
   logic [1:0][Q_BITS-1:0]       prev_acc [Q_BITS];
   logic [1:0][FB-1:0]           rem_in   [Q_BITS];
   logic [1:0][Q_BITS-1:0]       acc_in   [Q_BITS];

   // first stage loads the top numerator bits, which are always below the divisor
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         prev_rem[0][l] = FB'(prod[l][PROD_BITS-1 -: dpbp_pkg::FOCAL_MIN_BITS]);
         prev_acc[0][l] = {prod[l][LOW_BITS-1:0], {dpbp_pkg::FRAC_BITS{1'b0}}};
      end
      for (int k = 1; k < Q_BITS; k++) begin
         prev_rem[k] = rem_ff[k-1];
         prev_acc[k] = acc_ff[k-1];
      end
   end

   // one compare and subtract per stage and lane
   always_comb begin
      logic [FB:0] trial;
      logic        take;
      for (int k = 0; k < Q_BITS; k++) begin
         for (int l = 0; l < 2; l++) begin
            trial        = {prev_rem[k][l], prev_acc[k][l][Q_BITS-1]};
            take         = (trial >= {1'b0, focal});
            rem_in[k][l] = take ? FB'(trial - {1'b0, focal}) : trial[FB-1:0];
            acc_in[k][l] = {prev_acc[k][l][Q_BITS-2:0], take};
         end
      end
   end

   // valid bits follow the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < Q_BITS; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < Q_BITS; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= side_in;
         for (int k = 0; k < Q_BITS; k++) begin
            rem_ff[k] <= rem_in[k];
            acc_ff[k] <= acc_in[k];
         end
         for (int k = 1; k < Q_BITS; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[Q_BITS-1];
   assign quot      = acc_ff[Q_BITS-1];
   assign side_out  = side_ff[Q_BITS-1];

endmodule

// ----- hdl/dpbp_out.sv -----
// result formatting (sign, saturation, mode select) and the output register with skid
module dpbp_out #(
   parameter int Q_BITS = 44
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   input  logic [1:0][Q_BITS-1:0]                  quot,
   input  dpbp_pkg::side_type                      side,
   output logic                                    advance,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output logic signed [dpbp_pkg::OUT_XY_BITS-1:0] point_x,
   output logic signed [dpbp_pkg::OUT_XY_BITS-1:0] point_y,
   output logic [dpbp_pkg::OUT_Z_BITS-1:0]         point_z
);

   localparam int XY   = dpbp_pkg::OUT_XY_BITS;
   localparam int ZB   = dpbp_pkg::OUT_Z_BITS;
   localparam int WIDE = ((Q_BITS > XY) ? Q_BITS : XY) + 1;

   logic [WIDE-1:0] q_x;
   logic [WIDE-1:0] q_y;
   logic [WIDE-1:0] lim_max;
   logic [WIDE-1:0] lim_min;
   logic [XY-1:0]   sat_x;
   logic [XY-1:0]   sat_y;
   logic [XY-1:0]   x_in;
   logic [XY-1:0]   y_in;
   logic [ZB-1:0]   z_in;
   logic            push;
   logic            pop;

   logic            out_valid_ff;
   logic            skid_valid_ff;
   logic [XY-1:0]   out_x_ff;
   logic [XY-1:0]   out_y_ff;
   logic [ZB-1:0]   out_z_ff;
   logic [XY-1:0]   skid_x_ff;
   logic [XY-1:0]   skid_y_ff;
   logic [ZB-1:0]   skid_z_ff;

   // sign and saturate; y points up so its sign is flipped
   always_comb begin
      q_x     = WIDE'(quot[0]);
      q_y     = WIDE'(quot[1]);
      lim_max = WIDE'(dpbp_pkg::XY_MAX);
      lim_min = WIDE'(dpbp_pkg::XY_MIN);
      sat_x   = (q_x > lim_max) ? dpbp_pkg::XY_MAX : q_x[XY-1:0];
      sat_y   = (q_y > lim_max) ? dpbp_pkg::XY_MAX : q_y[XY-1:0];
      if (side.mode == dpbp_pkg::MODE_COLOR) begin
         x_in = XY'(side.red_q);
         y_in = XY'(side.green_q);
      end else begin
         if (side.neg_x) begin
            x_in = (q_x > lim_min) ? dpbp_pkg::XY_MIN : (~q_x[XY-1:0] + XY'(1));
         end else begin
            x_in = sat_x;
         end
         y_in = side.neg_y ? sat_y : (~sat_y + XY'(1));
      end
      z_in = side.point_z;
   end

   // pipeline moves while the skid slot is free
   assign advance = ~skid_valid_ff;
   assign push    = advance & in_valid;
   assign pop     = out_valid_ff & out_ready;

   // output and skid occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         if (out_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end
   end

   // output and skid data
   always_ff @(posedge clock) begin
      if (pop && skid_valid_ff) begin
         out_x_ff <= skid_x_ff;
         out_y_ff <= skid_y_ff;
         out_z_ff <= skid_z_ff;
      end else if (push && (pop || !out_valid_ff)) begin
         out_x_ff <= x_in;
         out_y_ff <= y_in;
         out_z_ff <= z_in;
      end
      if (push && out_valid_ff && !pop) begin
         skid_x_ff <= x_in;
         skid_y_ff <= y_in;
         skid_z_ff <= z_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign point_x   = out_x_ff;
   assign point_y   = out_y_ff;
   assign point_z   = out_z_ff;

endmodule

// ----- hdl/depth_pixel_back_projection_core.sv -----
// top level of the depth pixel back-projection core
// Takes one pixel per clock while no stall holds the pipeline and returns one result
// per pixel, in order. In depth mode the pixel becomes a pinhole camera point
// x = (col-cx)*d/f, y = -(row-cy)*d/f in signed Q32.16 with truncation toward zero
// and z = d in unsigned Q16.16; in color mode the result is red, green and blue
// over 255 in Q16.16. A new request is taken every cycle unless stalled. The
// pipeline holds two front stages for the offsets and the 20x16 product, one stage
// per quotient bit (DEPTH_BITS + 28 of them) in the two-lane restoring divider by
// the focal length, and the output register. A skid slot at the output lets the
// pipeline take one more request after the result side stops; beyond that a stall
// holds every stage in place. Configuration is read live and must be written only
// while no request is in flight.
module depth_pixel_back_projection_core #(
   parameter int COORD_BITS = 12,
   parameter int DEPTH_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [dpbp_pkg::PIXEL_BITS-1:0]         req_pixel_column,
   input  logic [dpbp_pkg::PIXEL_BITS-1:0]         req_pixel_row,
   input  logic [dpbp_pkg::DEPTH_IN_BITS-1:0]      req_depth_value,
   input  logic [dpbp_pkg::LEVEL_BITS-1:0]         req_red_level,
   input  logic [dpbp_pkg::LEVEL_BITS-1:0]         req_green_level,
   input  logic [dpbp_pkg::LEVEL_BITS-1:0]         req_blue_level,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [dpbp_pkg::OUT_XY_BITS-1:0] rsp_point_x,
   output logic signed [dpbp_pkg::OUT_XY_BITS-1:0] rsp_point_y,
   output logic [dpbp_pkg::OUT_Z_BITS-1:0]         rsp_point_z,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [dpbp_pkg::CSR_ADDR_BITS-1:0]      csr_paddr,
   input  logic [dpbp_pkg::CSR_DATA_BITS-1:0]      csr_pwdata,
   output logic [dpbp_pkg::CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                                    csr_pready
);

   localparam int COL_BITS  = (COORD_BITS < dpbp_pkg::PIXEL_BITS) ?
                              COORD_BITS : dpbp_pkg::PIXEL_BITS;
   localparam int MAG_BITS  = (COL_BITS + dpbp_pkg::SUBPIX_BITS > dpbp_pkg::CENTER_BITS) ?
                              (COL_BITS + dpbp_pkg::SUBPIX_BITS) : dpbp_pkg::CENTER_BITS;
   localparam int PROD_BITS = MAG_BITS + DEPTH_BITS;
   localparam int Q_BITS    = PROD_BITS + dpbp_pkg::FRAC_BITS - dpbp_pkg::FOCAL_MIN_BITS;

   dpbp_pkg::cfg_type         cfg;
   logic                      advance;
   logic                      front_valid;
   logic [1:0][PROD_BITS-1:0] front_prod;
   dpbp_pkg::side_type        front_side;
   logic                      div_valid;
   logic [1:0][Q_BITS-1:0]    div_quot;
   dpbp_pkg::side_type        div_side;

   assign req_ready = advance;

   // configuration registers
   dpbp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // offsets and products
   dpbp_front #(
      .COL_BITS   (COL_BITS),
      .DEPTH_BITS (DEPTH_BITS),
      .MAG_BITS   (MAG_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (req_valid),
      .pixel_column (req_pixel_column),
      .pixel_row    (req_pixel_row),
      .depth_value  (req_depth_value),
      .red_level    (req_red_level),
      .green_level  (req_green_level),
      .blue_level   (req_blue_level),
      .cfg          (cfg),
      .out_valid    (front_valid),
      .prod         (front_prod),
      .side         (front_side)
   );

   // division by the focal length
   dpbp_div_pipe #(
      .PROD_BITS (PROD_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .prod      (front_prod),
      .focal     (cfg.focal),
      .side_in   (front_side),
      .out_valid (div_valid),
      .quot      (div_quot),
      .side_out  (div_side)
   );

   // formatting and output buffering
   dpbp_out #(
      .Q_BITS (Q_BITS)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .quot      (div_quot),
      .side      (div_side),
      .advance   (advance),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .point_x   (rsp_point_x),
      .point_y   (rsp_point_y),
      .point_z   (rsp_point_z)
   );

endmodule

// ----- verif/tb_depth_pixel_back_projection_core.sv -----
`timescale 1ns / 100ps
// testbench for the depth pixel back-projection core: directed table, random phases, predictor
module tb_depth_pixel_back_projection_core;

   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int RANDOM_PHASES    = 8;
   localparam int PIXELS_PER_PHASE = 230;
   localparam int PRESSURE_PHASE   = 3;
   localparam int SETTLE_CYCLES    = 64;
   localparam int REG_COUNT        = 4;

   // camera settings used by the directed table
   localparam int CAM_RESET      = 0;
   localparam int CAM_TINY_FOCAL = 1;
   localparam int CAM_FAR_CENTER = 2;
   localparam int CAM_WIDE_FOCAL = 3;
   localparam int CAM_COLOR      = 4;
   localparam int CAM_COUNT      = 5;

   typedef longint unsigned u64_type;

   localparam longint XY_HI = (longint'(1) <<< (dpbp_pkg::OUT_XY_BITS - 1)) - 1;
   localparam longint XY_LO = -(longint'(1) <<< (dpbp_pkg::OUT_XY_BITS - 1));

   typedef struct packed {
      logic [dpbp_pkg::PIXEL_BITS-1:0]    column;
      logic [dpbp_pkg::PIXEL_BITS-1:0]    row;
      logic [dpbp_pkg::DEPTH_IN_BITS-1:0] depth;
      logic [dpbp_pkg::LEVEL_BITS-1:0]    red;
      logic [dpbp_pkg::LEVEL_BITS-1:0]    green;
      logic [dpbp_pkg::LEVEL_BITS-1:0]    blue;
   } pixel_type;

   typedef struct {
      logic signed [dpbp_pkg::OUT_XY_BITS-1:0] x;
      logic signed [dpbp_pkg::OUT_XY_BITS-1:0] y;
      logic [dpbp_pkg::OUT_Z_BITS-1:0]         z;
   } point_type;

   typedef struct {
      logic                             mode;
      logic [dpbp_pkg::FOCAL_BITS-1:0]  focal;
      logic [dpbp_pkg::CENTER_BITS-1:0] cx;
      logic [dpbp_pkg::CENTER_BITS-1:0] cy;
   } camera_type;

   typedef struct {
      int        cam_sel;
      pixel_type pix;
      bit        known;
      point_type want;
   } vector_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [dpbp_pkg::PIXEL_BITS-1:0] req_pixel_column;
   logic [dpbp_pkg::PIXEL_BITS-1:0] req_pixel_row;
   logic [dpbp_pkg::DEPTH_IN_BITS-1:0] req_depth_value;
   logic [dpbp_pkg::LEVEL_BITS-1:0] req_red_level;
   logic [dpbp_pkg::LEVEL_BITS-1:0] req_green_level;
   logic [dpbp_pkg::LEVEL_BITS-1:0] req_blue_level;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [dpbp_pkg::OUT_XY_BITS-1:0] rsp_point_x;
   logic signed [dpbp_pkg::OUT_XY_BITS-1:0] rsp_point_y;
   logic [dpbp_pkg::OUT_Z_BITS-1:0] rsp_point_z;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [dpbp_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [dpbp_pkg::CSR_DATA_BITS-1:0] csr_pwdata;
   logic [dpbp_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   camera_type cam;
   point_type  pending_points[$];
   vector_type vectors[$];
   bit         quiet_tail = 1'b0;
   int         error_count = 0;
   int         pixels_sent = 0;
   int         color_pixels = 0;
   int         results_checked = 0;
   int         cameras_used = 0;
   int         stall_left = 0;
   int         idle_cycles = 0;

   depth_pixel_back_projection_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_column (req_pixel_column),
      .req_pixel_row    (req_pixel_row),
      .req_depth_value  (req_depth_value),
      .req_red_level    (req_red_level),
      .req_green_level  (req_green_level),
      .req_blue_level   (req_blue_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_point_x      (rsp_point_x),
      .rsp_point_y      (rsp_point_y),
      .rsp_point_z      (rsp_point_z),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // offset * d * 2^16 / f, truncated toward zero, clipped to signed 48 bits
   function automatic longint scale_offset(longint offset, u64_type depth, u64_type focal);
      u64_type mag;
      u64_type quo;
      mag = (offset < 0) ? u64_type'(-offset) : u64_type'(offset);
      quo = ((mag * depth) << dpbp_pkg::FRAC_BITS) / focal;
      if (offset >= 0)
         return (quo > u64_type'(XY_HI)) ? XY_HI : longint'(quo);
      return (quo > u64_type'(XY_HI) + 1) ? XY_LO : -longint'(quo);
   endfunction

   // expected point for one pixel under the given camera setting
   function automatic point_type project_pixel(pixel_type pix, camera_type c);
      point_type pt;
      longint    off_x;
      longint    off_y;
      longint    px;
      longint    py;
      u64_type   depth;
      u64_type   focal;
      if (c.mode == dpbp_pkg::MODE_DEPTH) begin
         depth = u64_type'(pix.depth);
         focal = (c.focal < dpbp_pkg::FOCAL_MIN) ? u64_type'(dpbp_pkg::FOCAL_MIN) :
                                                   u64_type'(c.focal);
         off_x = longint'({pix.column, 8'h00}) - longint'(c.cx);
         off_y = longint'({pix.row, 8'h00}) - longint'(c.cy);
         px = scale_offset(off_x, depth, focal);
         py = scale_offset(off_y, depth, focal);
         // camera y points up, so the row offset is flipped
         py = (py == XY_LO) ? XY_HI : -py;
         pt.x = px[dpbp_pkg::OUT_XY_BITS-1:0];
         pt.y = py[dpbp_pkg::OUT_XY_BITS-1:0];
         pt.z = dpbp_pkg::OUT_Z_BITS'(depth << dpbp_pkg::FRAC_BITS);
      end else begin
         pt.x = dpbp_pkg::OUT_XY_BITS'((u64_type'(pix.red) << dpbp_pkg::FRAC_BITS) /
                                       u64_type'(dpbp_pkg::LEVEL_FULL));
         pt.y = dpbp_pkg::OUT_XY_BITS'((u64_type'(pix.green) << dpbp_pkg::FRAC_BITS) /
                                       u64_type'(dpbp_pkg::LEVEL_FULL));
         pt.z = dpbp_pkg::OUT_Z_BITS'((u64_type'(pix.blue) << dpbp_pkg::FRAC_BITS) /
                                      u64_type'(dpbp_pkg::LEVEL_FULL));
      end
      return pt;
   endfunction

   function automatic logic [dpbp_pkg::CENTER_BITS-1:0] random_center();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         2: return dpbp_pkg::CENTER_BITS'($urandom_range(0, 4095 * 256));
         default: return dpbp_pkg::CENTER_BITS'($urandom);
      endcase
   endfunction

   function automatic camera_type random_camera();
      camera_type c;
      c.mode = ($urandom_range(0, 3) == 0) ? dpbp_pkg::MODE_COLOR : dpbp_pkg::MODE_DEPTH;
      case ($urandom_range(0, 3))
         0: c.focal = dpbp_pkg::FOCAL_BITS'($urandom_range(0, 255));
         1: c.focal = '1;
         2: c.focal = dpbp_pkg::FOCAL_BITS'($urandom_range(256, 400000));
         default: c.focal = dpbp_pkg::FOCAL_BITS'($urandom);
      endcase
      c.cx = random_center();
      c.cy = random_center();
      return c;
   endfunction

   // random pixel, pushed toward field extremes now and then
   function automatic pixel_type random_pixel();
      pixel_type p;
      p = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: p.column = '0;
         1: p.column = '1;
         2: p.row = '0;
         3: p.row = '1;
         4: p.depth = '0;
         5: p.depth = '1;
         6: {p.red, p.green, p.blue} = '1;
         7: {p.red, p.green, p.blue} = '0;
         8: begin
            p.column = dpbp_pkg::PIXEL_BITS'($urandom_range(0, 639));
            p.row    = dpbp_pkg::PIXEL_BITS'($urandom_range(0, 479));
         end
         default: ;
      endcase
      return p;
   endfunction

   task automatic add_vector(int cam_sel, int col, int row, int depth, int red, int green,
                             int blue, bit known, longint x, longint y, longint z);
      vector_type v;
      v.cam_sel    = cam_sel;
      v.pix.column = dpbp_pkg::PIXEL_BITS'(col);
      v.pix.row    = dpbp_pkg::PIXEL_BITS'(row);
      v.pix.depth  = dpbp_pkg::DEPTH_IN_BITS'(depth);
      v.pix.red    = dpbp_pkg::LEVEL_BITS'(red);
      v.pix.green  = dpbp_pkg::LEVEL_BITS'(green);
      v.pix.blue   = dpbp_pkg::LEVEL_BITS'(blue);
      v.known      = known;
      v.want.x     = x[dpbp_pkg::OUT_XY_BITS-1:0];
      v.want.y     = y[dpbp_pkg::OUT_XY_BITS-1:0];
      v.want.z     = z[dpbp_pkg::OUT_Z_BITS-1:0];
      vectors      = {vectors, v};
   endtask

   // one apb transfer: setup cycle, then access cycle
   task automatic csr_access(input dpbp_pkg::reg_index_type idx, input bit wr,
                             input logic [dpbp_pkg::CSR_DATA_BITS-1:0] data,
                             output logic [dpbp_pkg::CSR_DATA_BITS-1:0] rdata);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = wr;
      csr_paddr   = dpbp_pkg::CSR_ADDR_BITS'({idx, 2'b00});
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // write every register, optionally with junk above the field, and read it back
   task automatic program_camera(camera_type c, bit dirty);
      logic [dpbp_pkg::CSR_DATA_BITS-1:0] field [REG_COUNT];
      logic [dpbp_pkg::CSR_DATA_BITS-1:0] keep [REG_COUNT];
      logic [dpbp_pkg::CSR_DATA_BITS-1:0] junk;
      logic [dpbp_pkg::CSR_DATA_BITS-1:0] rd;
      dpbp_pkg::reg_index_type idx;
      field[dpbp_pkg::REG_MODE]     = dpbp_pkg::CSR_DATA_BITS'(c.mode);
      field[dpbp_pkg::REG_FOCAL]    = dpbp_pkg::CSR_DATA_BITS'(c.focal);
      field[dpbp_pkg::REG_CENTER_X] = dpbp_pkg::CSR_DATA_BITS'(c.cx);
      field[dpbp_pkg::REG_CENTER_Y] = dpbp_pkg::CSR_DATA_BITS'(c.cy);
      keep[dpbp_pkg::REG_MODE]      = dpbp_pkg::CSR_DATA_BITS'(1);
      keep[dpbp_pkg::REG_FOCAL]     =
         (dpbp_pkg::CSR_DATA_BITS'(1) << dpbp_pkg::FOCAL_BITS) - 1;
      keep[dpbp_pkg::REG_CENTER_X]  =
         (dpbp_pkg::CSR_DATA_BITS'(1) << dpbp_pkg::CENTER_BITS) - 1;
      keep[dpbp_pkg::REG_CENTER_Y]  = keep[dpbp_pkg::REG_CENTER_X];
      idx = idx.first();
      repeat (idx.num()) begin
         junk = dirty ? dpbp_pkg::CSR_DATA_BITS'($urandom) : '0;
         csr_access(idx, 1'b1, field[idx] | (junk & ~keep[idx]), rd);
         csr_access(idx, 1'b0, '0, rd);
         if (rd !== field[idx]) begin
            $error("register %s readback: expected %0h, actual %0h", idx.name(), field[idx], rd);
            error_count++;
         end
         idx = idx.next();
      end
      cam = c;
      cameras_used++;
   endtask

   // hold the request until it is taken, then queue its point
   task automatic push_pixel(pixel_type pix, point_type want);
      @(negedge clock);
      req_valid        = 1'b1;
      req_pixel_column = pix.column;
      req_pixel_row    = pix.row;
      req_depth_value  = pix.depth;
      req_red_level    = pix.red;
      req_green_level  = pix.green;
      req_blue_level   = pix.blue;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_points = {pending_points, want};
      pixels_sent++;
      if (cam.mode == dpbp_pkg::MODE_COLOR)
         color_pixels++;
   endtask

   task automatic sender_gap(int cycles);
      @(negedge clock);
      req_valid        = 1'b0;
      req_pixel_column = dpbp_pkg::PIXEL_BITS'($urandom);
      req_depth_value  = dpbp_pkg::DEPTH_IN_BITS'($urandom);
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic maybe_gap();
      if (!quiet_tail && $urandom_range(0, 5) == 0)
         sender_gap($urandom_range(1, 14));
   endtask

   task automatic drain_points();
      sender_gap(1);
      while (pending_points.size() != 0) @(posedge clock);
   endtask

   // result side stalls in bursts
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 14) - 1;
         rsp_ready  = 1'b0;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   // result check and watchdog
   always @(posedge clock) begin : check_results
      point_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_points.size() == 0) begin
            $error("result with no request pending: x %0d y %0d z %0d",
                   rsp_point_x, rsp_point_y, rsp_point_z);
            error_count++;
         end else begin
            want = pending_points.pop_front();
            results_checked++;
            if (rsp_point_x !== want.x) begin
               $error("point_x: expected %0d, actual %0d", want.x, rsp_point_x);
               error_count++;
            end
            if (rsp_point_y !== want.y) begin
               $error("point_y: expected %0d, actual %0d", want.y, rsp_point_y);
               error_count++;
            end
            if (rsp_point_z !== want.z) begin
               $error("point_z: expected %0d, actual %0d", want.z, rsp_point_z);
               error_count++;
            end
         end
      end
      if ((req_valid && req_ready) || (rsp_valid === 1'b1 && rsp_ready) ||
          (csr_psel && csr_penable))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      camera_type plan[CAM_COUNT];
      vector_type v;
      pixel_type  pix;
      int         active_cam;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_pixel_column = '0;
      req_pixel_row    = '0;
      req_depth_value  = '0;
      req_red_level    = '0;
      req_green_level  = '0;
      req_blue_level   = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      cam = '{dpbp_pkg::MODE_DEPTH, dpbp_pkg::FOCAL_RESET, dpbp_pkg::CENTER_X_RESET,
              dpbp_pkg::CENTER_Y_RESET};

      // camera settings for the directed part
      plan[CAM_RESET]      = cam;
      plan[CAM_TINY_FOCAL] = '{dpbp_pkg::MODE_DEPTH, '0, '0, '0};
      plan[CAM_FAR_CENTER] = '{dpbp_pkg::MODE_DEPTH, dpbp_pkg::FOCAL_BITS'(255), '1, '1};
      plan[CAM_WIDE_FOCAL] = '{dpbp_pkg::MODE_DEPTH, '1, '0, '1};
      plan[CAM_COLOR]      = '{dpbp_pkg::MODE_COLOR, dpbp_pkg::FOCAL_RESET,
                               dpbp_pkg::CENTER_X_RESET, dpbp_pkg::CENTER_Y_RESET};

      // directed table: cam, col, row, depth, r, g, b, known, x, y, z
      add_vector(CAM_RESET, 0, 0, 0, 255, 255, 255, 1, 0, 0, 0);
      add_vector(CAM_RESET, 320, 240, 65535, 0, 0, 0, 1, 0, 0, 64'hFFFF_0000);
      add_vector(CAM_RESET, 0, 0, 65535, 0, 0, 0, 0, 0, 0, 0);
      add_vector(CAM_RESET, 4095, 4095, 65535, 0, 0, 0, 0, 0, 0, 0);
      add_vector(CAM_RESET, 4095, 0, 1, 0, 0, 0, 0, 0, 0, 0);
      add_vector(CAM_RESET, 0, 4095, 1234, 0, 0, 0, 0, 0, 0, 0);
      // one pixel off center at depth f gives exactly one unit
      add_vector(CAM_RESET, 321, 239, 521, 0, 0, 0, 1, 65536, 65536, 521 * 65536);
      // focal of zero is taken as one pixel
      add_vector(CAM_TINY_FOCAL, 1, 1, 1, 0, 0, 0, 1, 65536, -65536, 65536);
      add_vector(CAM_TINY_FOCAL, 4095, 4095, 65535, 0, 0, 0, 0, 0, 0, 0);
      add_vector(CAM_FAR_CENTER, 0, 0, 65535, 0, 0, 0, 0, 0, 0, 0);
      add_vector(CAM_FAR_CENTER, 4095, 4095, 65535, 0, 0, 0, 0, 0, 0, 0);
      add_vector(CAM_FAR_CENTER, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
      add_vector(CAM_WIDE_FOCAL, 4095, 0, 65535, 0, 0, 0, 0, 0, 0, 0);
      add_vector(CAM_WIDE_FOCAL, 4095, 4095, 1, 0, 0, 0, 0, 0, 0, 0);
      // color mode ignores position and depth
      add_vector(CAM_COLOR, 4095, 4095, 65535, 0, 0, 0, 1, 0, 0, 0);
      add_vector(CAM_COLOR, 0, 0, 0, 255, 255, 255, 1, 65536, 65536, 65536);
      add_vector(CAM_COLOR, 17, 900, 300, 1, 128, 254, 0, 0, 0, 0);
      add_vector(CAM_COLOR, 2048, 1, 7, 8'hAA, 8'h55, 8'h0F, 0, 0, 0, 0);
      add_vector(CAM_RESET, 321, 239, 521, 0, 0, 0, 1, 65536, 65536, 521 * 65536);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part
      active_cam = CAM_RESET;
      foreach (vectors[i]) begin
         v = vectors[i];
         if (v.cam_sel != active_cam) begin
            drain_points();
            program_camera(plan[v.cam_sel], 1'b0);
            active_cam = v.cam_sel;
         end
         push_pixel(v.pix, v.known ? v.want : project_pixel(v.pix, cam));
         maybe_gap();
      end

      // random phases, each under a fresh camera setting
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_points();
         program_camera(random_camera(), 1'b1);
         if (phase == RANDOM_PHASES - 1)
            quiet_tail = 1'b1;
         for (int k = 0; k < PIXELS_PER_PHASE; k++) begin
            pix = random_pixel();
            push_pixel(pix, project_pixel(pix, cam));
            // let the pipeline run dry once mid-stream
            if (phase == PRESSURE_PHASE && k == PIXELS_PER_PHASE / 2)
               drain_points();
            else
               maybe_gap();
         end
      end

      drain_points();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d pixels (%0d in color mode) under %0d camera settings",
               pixels_sent, color_pixels, cameras_used + 1);
      $display("%0d results checked against the projection model", results_checked);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
